@@ design/rrs_pkg.sv @@
// Package: shared constants, types and a helper function of the RAID-5 request splitter.
`timescale 1ns / 1ps
package rrs_pkg;

  localparam int ADDR_W         = 48;
  localparam int LEN_W          = 21;
  localparam int DISK_W         = 3;
  localparam int CFG_W          = 4;
  localparam int KIND_W         = 2;
  localparam int CHUNK_KIB      = 64;
  localparam int CHUNK_BYTES    = CHUNK_KIB * 1024;
  localparam int CHUNK_LOG2     = $clog2(CHUNK_BYTES);
  localparam int MAX_DISK_COUNT = 8;
  localparam int MIN_DISK_COUNT = 3;
  localparam int MAX_REQ_LEN    = 1048576;
  localparam int Q_W            = ADDR_W + 1 - CHUNK_LOG2;
  localparam int MAP_IDX_W      = $clog2(MAX_DISK_COUNT);

  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PARITY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PRE    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERR    = 2'd3;

  localparam logic [1:0] USE_NONE = 2'd0;
  localparam logic [1:0] USE_FULL = 2'd1;
  localparam logic [1:0] USE_PART = 2'd2;

  // datapath commands
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] DP_NOP   = 4'd0;
  localparam logic [OP_W-1:0] DP_LOAD  = 4'd1;
  localparam logic [OP_W-1:0] DP_DIV1  = 4'd2;
  localparam logic [OP_W-1:0] DP_TAKE1 = 4'd3;
  localparam logic [OP_W-1:0] DP_DIV2  = 4'd4;
  localparam logic [OP_W-1:0] DP_TAKE2 = 4'd5;
  localparam logic [OP_W-1:0] DP_OPEN  = 4'd6;
  localparam logic [OP_W-1:0] DP_DATA  = 4'd7;
  localparam logic [OP_W-1:0] DP_PRE   = 4'd8;
  localparam logic [OP_W-1:0] DP_ERR   = 4'd9;

  typedef logic [MAX_DISK_COUNT-1:0][1:0] usage_map_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic len_over;
    logic div_done;
    logic last_slice;
    logic wrap;
    logic is_wr;
    logic slot_free;
    logic mask_zero;
    logic mask_one;
  } dp_status_t;

  // Disks to pre-read: reconstruct mode picks the disks not fully written,
  // read-modify mode picks every disk that was touched.
  function automatic logic [MAX_DISK_COUNT-1:0] pick_mask(usage_map_t m,
                                                          logic [CFG_W-1:0] n);
    logic [CFG_W:0] cnt;
    logic rcw;
    logic [MAX_DISK_COUNT-1:0] pm;
    cnt = '0;
    for (int i = 0; i < MAX_DISK_COUNT; i++) begin
      if ((CFG_W'(i) < n) && (m[i] != USE_FULL)) cnt = cnt + 1'b1;
    end
    rcw = (cnt <= {1'b0, (n >> 1)});
    for (int i = 0; i < MAX_DISK_COUNT; i++) begin
      pm[i] = (CFG_W'(i) < n) && (rcw ? (m[i] != USE_FULL) : (m[i] != USE_NONE));
    end
    return pm;
  endfunction

endpackage

@@ design/raid5_request_splitter.sv @@
// Top level: RAID-5 request splitter with rotating parity, stream in and out.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: offset[47:0], length[68:48]; tuser: is_write
//  out_    | out | out_tvalid/tready  | tdata: disk, offset, length; tuser: is_write, kind;
//          |     |                    | tlast: last piece of the request
//  cfg_    | in  | cfg_we             | cfg_wdata: disk count
//
// Sequence: after an item is taken, setup (load, then two 33-step divisions on the
// shared bit-serial divider, chunk index by data-disk count and stripe by disk count),
// then one result per cycle while the output is not held, plus an open step per stripe
// on reads that gives no result, and a closing step on a write with no pre-reads.
// Zero length requests give no result; oversize ones give a single error item.
// Reset: rst_n, synchronous, low; the disk count returns to 4.
// Stalls: a held result blocks only the next result; setup work goes on.
`timescale 1ns / 1ps
module raid5_request_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // request_offset[47:0], request_length[68:48], zeros
  input  logic        in_tuser,   // request_is_write
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // target_disk[2:0], disk_byte_offset[50:3],
                                  // piece_length[71:51]
  output logic [2:0]  out_tuser,  // piece_is_write[0], piece_kind[2:1]
  output logic        out_tlast   // last_piece
);
  rrs_pkg::dp_cmd_t    cmd;
  rrs_pkg::dp_status_t status;

  logic [rrs_pkg::DISK_W-1:0] o_disk;
  logic [rrs_pkg::ADDR_W-1:0] o_off;
  logic [rrs_pkg::LEN_W-1:0]  o_len;
  logic                       o_wr;
  logic [rrs_pkg::KIND_W-1:0] o_kind;

  // sequence the request
  rrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // hold request, walk stripes and drive the output register
  rrs_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_offset    (in_tdata[47:0]),
    .in_length    (in_tdata[68:48]),
    .in_is_write  (in_tuser),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_disk     (o_disk),
    .out_offset   (o_off),
    .out_length   (o_len),
    .out_is_write (o_wr),
    .out_kind     (o_kind),
    .out_last     (out_tlast)
  );

  assign out_tdata = {o_len, o_off, o_disk};
  assign out_tuser = {o_kind, o_wr};
endmodule

@@ design/rrs_divider.sv @@
// Iterative restoring divider: one quotient bit per cycle, small divisor.
`timescale 1ns / 1ps
module rrs_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rrs_pkg::Q_W-1:0]     dividend,
  input  logic [rrs_pkg::CFG_W-1:0]   divisor,
  output logic                        done,
  output logic [rrs_pkg::Q_W-1:0]     quot,
  output logic [rrs_pkg::CFG_W-1:0]   rem
);
  localparam int CNT_W = $clog2(rrs_pkg::Q_W + 1);

  logic [CNT_W-1:0]          cnt_r;
  logic                      done_r;
  logic [rrs_pkg::Q_W-1:0]   quot_r;
  logic [rrs_pkg::CFG_W-1:0] rem_r;
  logic [rrs_pkg::CFG_W-1:0] dvs_r;
  logic [rrs_pkg::CFG_W:0]   trial;
  logic                      ge;

  assign trial = {rem_r, quot_r[rrs_pkg::Q_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      // flag the cycle after the last quotient bit
      done_r <= !start && (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r  <= CNT_W'(rrs_pkg::Q_W);
        quot_r <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (cnt_r != '0) begin
        rem_r  <= ge ? rrs_pkg::CFG_W'(trial - {1'b0, dvs_r})
                     : trial[rrs_pkg::CFG_W-1:0];
        quot_r <= {quot_r[rrs_pkg::Q_W-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;
endmodule

@@ design/rrs_datapath.sv @@
// Datapath: request registers, stripe walk, usage map, divider and output register.
`timescale 1ns / 1ps
module rrs_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rrs_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [rrs_pkg::ADDR_W-1:0]    in_offset,
  input  logic [rrs_pkg::LEN_W-1:0]     in_length,
  input  logic                          in_is_write,
  input  rrs_pkg::dp_cmd_t              cmd,
  output rrs_pkg::dp_status_t           status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rrs_pkg::DISK_W-1:0]    out_disk,
  output logic [rrs_pkg::ADDR_W-1:0]    out_offset,
  output logic [rrs_pkg::LEN_W-1:0]     out_length,
  output logic                          out_is_write,
  output logic [rrs_pkg::KIND_W-1:0]    out_kind,
  output logic                          out_last
);
  localparam logic [rrs_pkg::LEN_W-1:0] CHUNK_LEN = rrs_pkg::LEN_W'(rrs_pkg::CHUNK_BYTES);

  logic [rrs_pkg::CFG_W-1:0]          dc_r;
  logic [rrs_pkg::CFG_W-1:0]          n_r;
  logic [rrs_pkg::ADDR_W-1:0]         off_r;
  logic [rrs_pkg::LEN_W-1:0]          len_r;
  logic [rrs_pkg::LEN_W-1:0]          rem_r;
  logic                               wr_r;
  logic [rrs_pkg::Q_W-1:0]            q_r;
  logic [rrs_pkg::Q_W-1:0]            sid_r;
  logic [rrs_pkg::DISK_W-1:0]         did_r;
  logic [rrs_pkg::DISK_W-1:0]         pd_r;
  logic [rrs_pkg::ADDR_W-1:0]         base_r;
  rrs_pkg::usage_map_t                map_r;
  logic [rrs_pkg::MAX_DISK_COUNT-1:0] mask_r;

  logic                               out_valid_r;
  logic [rrs_pkg::DISK_W-1:0]         out_disk_r;
  logic [rrs_pkg::ADDR_W-1:0]         out_offset_r;
  logic [rrs_pkg::LEN_W-1:0]          out_length_r;
  logic                               out_is_write_r;
  logic [rrs_pkg::KIND_W-1:0]         out_kind_r;
  logic                               out_last_r;

  logic                               div_start;
  logic [rrs_pkg::Q_W-1:0]            div_dividend;
  logic [rrs_pkg::CFG_W-1:0]          div_divisor;
  logic                               div_done;
  logic [rrs_pkg::Q_W-1:0]            div_quot;
  logic [rrs_pkg::CFG_W-1:0]          div_rem;

  logic                               slot_free;
  logic                               emit;
  logic                               last_slice;
  logic                               wrap;
  logic [rrs_pkg::LEN_W-1:0]          len_cur;
  logic [rrs_pkg::Q_W-1:0]            diff;
  logic [rrs_pkg::ADDR_W-1:0]         base_c;
  logic [rrs_pkg::DISK_W-1:0]         data_disk;
  rrs_pkg::usage_map_t                map_after;
  rrs_pkg::usage_map_t                map_open;
  logic [rrs_pkg::MAX_DISK_COUNT-1:0] mask_after;
  logic [rrs_pkg::MAX_DISK_COUNT-1:0] mask_rest;
  logic [rrs_pkg::DISK_W-1:0]         pre_disk;
  logic [rrs_pkg::CFG_W-1:0]          n_clamp;

  assign div_start    = (cmd.op == rrs_pkg::DP_DIV1) || (cmd.op == rrs_pkg::DP_DIV2);
  assign div_dividend = (cmd.op == rrs_pkg::DP_DIV2) ? sid_r : q_r;
  assign div_divisor  = (cmd.op == rrs_pkg::DP_DIV2) ? n_r : n_r - 1'b1;

  rrs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    if (dc_r < rrs_pkg::CFG_W'(rrs_pkg::MIN_DISK_COUNT))
      n_clamp = rrs_pkg::CFG_W'(rrs_pkg::MIN_DISK_COUNT);
    else if (dc_r > rrs_pkg::CFG_W'(rrs_pkg::MAX_DISK_COUNT))
      n_clamp = rrs_pkg::CFG_W'(rrs_pkg::MAX_DISK_COUNT);
    else
      n_clamp = dc_r;
  end

  assign slot_free  = !out_valid_r || out_ready;
  // a new item enters the output register this cycle
  assign emit       = (cmd.op == rrs_pkg::DP_DATA) || (cmd.op == rrs_pkg::DP_PRE) ||
                      (cmd.op == rrs_pkg::DP_ERR) || ((cmd.op == rrs_pkg::DP_OPEN) && wr_r);
  assign last_slice = (rem_r <= CHUNK_LEN);
  assign wrap       = ({1'b0, did_r} == (n_r - rrs_pkg::CFG_W'(2)));
  assign len_cur    = last_slice ? rem_r : CHUNK_LEN;
  // stripe start in host space is the chunk index less the data index
  assign diff       = q_r - rrs_pkg::Q_W'(did_r);
  assign base_c     = {diff[rrs_pkg::ADDR_W-rrs_pkg::CHUNK_LOG2-1:0],
                       off_r[rrs_pkg::CHUNK_LOG2-1:0]};
  assign data_disk  = (did_r < pd_r) ? did_r : did_r + 1'b1;

  always_comb begin
    map_after = map_r;
    map_after[data_disk] = (len_cur >= CHUNK_LEN) ? rrs_pkg::USE_FULL : rrs_pkg::USE_PART;
    map_open = '0;
    map_open[pd_r] = rrs_pkg::USE_FULL;
  end

  assign mask_after = rrs_pkg::pick_mask(map_after, n_r);
  assign mask_rest  = mask_r & (mask_r - 1'b1);

  always_comb begin
    pre_disk = '0;
    for (int i = rrs_pkg::MAX_DISK_COUNT - 1; i >= 0; i--) begin
      if (mask_r[i]) pre_disk = rrs_pkg::DISK_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r        <= rrs_pkg::CFG_W'(4);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) dc_r <= cfg_wdata;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (cmd.op)
        rrs_pkg::DP_LOAD: begin
          off_r <= in_offset;
          len_r <= in_length;
          rem_r <= in_length;
          wr_r  <= in_is_write;
          q_r   <= rrs_pkg::Q_W'(in_offset[rrs_pkg::ADDR_W-1:rrs_pkg::CHUNK_LOG2]);
          n_r   <= n_clamp;
        end
        rrs_pkg::DP_TAKE1: begin
          did_r <= div_rem[rrs_pkg::DISK_W-1:0];
          sid_r <= div_quot;
        end
        rrs_pkg::DP_TAKE2: begin
          pd_r <= div_rem[rrs_pkg::DISK_W-1:0];
        end
        rrs_pkg::DP_OPEN: begin
          base_r <= base_c;
          map_r  <= map_open;
          if (wr_r) begin
            out_disk_r     <= pd_r;
            out_offset_r   <= base_c;
            out_length_r   <= len_cur;
            out_is_write_r <= 1'b1;
            out_kind_r     <= rrs_pkg::KIND_PARITY;
            out_last_r     <= 1'b0;
          end
        end
        rrs_pkg::DP_DATA: begin
          out_disk_r     <= data_disk;
          out_offset_r   <= base_r;
          out_length_r   <= len_cur;
          out_is_write_r <= wr_r;
          out_kind_r     <= rrs_pkg::KIND_DATA;
          out_last_r     <= last_slice && (!wr_r || (mask_after == '0));
          map_r          <= map_after;
          mask_r         <= mask_after;
          rem_r          <= rem_r - CHUNK_LEN;
          q_r            <= q_r + 1'b1;
          if (wrap) begin
            did_r <= '0;
            pd_r  <= ({1'b0, pd_r} == n_r - 1'b1) ? '0 : pd_r + 1'b1;
          end else begin
            did_r <= did_r + 1'b1;
          end
        end
        rrs_pkg::DP_PRE: begin
          out_disk_r     <= pre_disk;
          out_offset_r   <= base_r;
          out_length_r   <= CHUNK_LEN;
          out_is_write_r <= 1'b0;
          out_kind_r     <= rrs_pkg::KIND_PRE;
          out_last_r     <= (mask_rest == '0);
          mask_r         <= mask_rest;
        end
        rrs_pkg::DP_ERR: begin
          out_disk_r     <= '0;
          out_offset_r   <= off_r;
          out_length_r   <= len_r;
          out_is_write_r <= wr_r;
          out_kind_r     <= rrs_pkg::KIND_ERR;
          out_last_r     <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    status.len_zero   = (len_r == '0);
    status.len_over   = (len_r > rrs_pkg::LEN_W'(rrs_pkg::MAX_REQ_LEN));
    status.div_done   = div_done;
    status.last_slice = last_slice;
    status.wrap       = wrap;
    status.is_wr      = wr_r;
    status.slot_free  = slot_free;
    status.mask_zero  = (mask_r == '0);
    status.mask_one   = (mask_rest == '0);
  end

  assign out_valid    = out_valid_r;
  assign out_disk     = out_disk_r;
  assign out_offset   = out_offset_r;
  assign out_length   = out_length_r;
  assign out_is_write = out_is_write_r;
  assign out_kind     = out_kind_r;
  assign out_last     = out_last_r;

`ifndef SYNTHESIS
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == rrs_pkg::KIND_ERR) |-> out_last_r)
    else $error("error item not marked last");
  a_par_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == rrs_pkg::KIND_PARITY) |-> !out_last_r)
    else $error("parity item marked last");
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rrs_pkg::DP_DATA) || (cmd.op == rrs_pkg::DP_PRE) ||
    (cmd.op == rrs_pkg::DP_ERR) |-> slot_free)
    else $error("item issued over a held item");
  a_disk_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r != rrs_pkg::KIND_ERR) |-> ({1'b0, out_disk_r} < n_r))
    else $error("target disk beyond disk count");
`endif
endmodule

@@ design/rrs_ctrl.sv @@
// Controller: sequences load, the two divisions, the stripe walk, the pre-reads and the error item.
`timescale 1ns / 1ps
module rrs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrs_pkg::dp_status_t status,
  output rrs_pkg::dp_cmd_t    cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_W1   = 4'd2;
  localparam logic [3:0] S_ST2  = 4'd3;
  localparam logic [3:0] S_W2   = 4'd4;
  localparam logic [3:0] S_OPEN = 4'd5;
  localparam logic [3:0] S_DATA = 4'd6;
  localparam logic [3:0] S_PRE  = 4'd7;
  localparam logic [3:0] S_ERR  = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = rrs_pkg::DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = rrs_pkg::DP_LOAD;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        priority if (status.len_zero) begin
          state_nxt = S_IDLE;
        end else if (status.len_over) begin
          state_nxt = S_ERR;
        end else begin
          cmd.op    = rrs_pkg::DP_DIV1;
          state_nxt = S_W1;
        end
      end
      S_W1: begin
        if (status.div_done) begin
          cmd.op    = rrs_pkg::DP_TAKE1;
          state_nxt = S_ST2;
        end
      end
      S_ST2: begin
        cmd.op    = rrs_pkg::DP_DIV2;
        state_nxt = S_W2;
      end
      S_W2: begin
        if (status.div_done) begin
          cmd.op    = rrs_pkg::DP_TAKE2;
          state_nxt = S_OPEN;
        end
      end
      S_OPEN: begin
        if (!status.is_wr || status.slot_free) begin
          cmd.op    = rrs_pkg::DP_OPEN;
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        if (status.slot_free) begin
          cmd.op = rrs_pkg::DP_DATA;
          priority if (status.last_slice) state_nxt = status.is_wr ? S_PRE : S_IDLE;
          else if (status.wrap)            state_nxt = S_OPEN;
          else                             state_nxt = S_DATA;
        end
      end
      S_PRE: begin
        priority if (status.mask_zero) begin
          state_nxt = S_IDLE;
        end else if (status.slot_free) begin
          cmd.op = rrs_pkg::DP_PRE;
          if (status.mask_one) state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (status.slot_free) begin
          cmd.op    = rrs_pkg::DP_ERR;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

`ifndef SYNTHESIS
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> (state_r == S_LOAD))
    else $error("accepted item not loaded");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ST2) |=> (state_r == S_W2))
    else $error("second division not started");
  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r <= S_ERR)
    else $error("controller in an unknown state");
`endif
endmodule

@@ bench/testbench.sv @@
// Testbench: streams host requests into the RAID-5 request splitter and checks every sub-request.
`timescale 1ns / 1ps
module testbench;

  localparam longint unsigned CHUNK  = rrs_pkg::CHUNK_BYTES;
  localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 200;

  typedef struct {
    logic [rrs_pkg::DISK_W-1:0] disk;
    logic [rrs_pkg::ADDR_W-1:0] offset;
    logic [rrs_pkg::LEN_W-1:0]  length;
    logic                       is_write;
    logic [rrs_pkg::KIND_W-1:0] kind;
    logic                       last;
  } piece_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  piece_t      pending_pieces[$];
  logic [3:0]  disk_setting;
  int          mismatches;
  int          requests_sent;
  int          pieces_seen;
  int          idle_cycles;
  bit          no_stall;

  raid5_request_splitter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string what);
    mismatches++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  // Work out the sub-requests of one accepted request and queue them.
  function automatic void split_request(input logic [rrs_pkg::ADDR_W-1:0] off,
                                        input logic [rrs_pkg::LEN_W-1:0] len,
                                        input logic wr);
    piece_t          list[$];
    piece_t          p;
    logic [1:0]      usage[rrs_pkg::MAX_DISK_COUNT];
    longint unsigned n, ss, e, s, l, sid, did, par, base, cur, disk, cnt;
    bit              open, rcw;
    n = disk_setting;
    if (n < rrs_pkg::MIN_DISK_COUNT) n = rrs_pkg::MIN_DISK_COUNT;
    if (n > rrs_pkg::MAX_DISK_COUNT) n = rrs_pkg::MAX_DISK_COUNT;
    ss = CHUNK * (n - 1);
    open = 0;
    cur = 0;
    par = 0;
    base = 0;
    foreach (usage[i]) usage[i] = rrs_pkg::USE_NONE;
    if (len == 0) return;
    if (len <= rrs_pkg::MAX_REQ_LEN) begin
      e = longint'(off) + longint'(len);
      for (s = off; s < e; s += CHUNK) begin
        l = (e - s < CHUNK) ? e - s : CHUNK;
        sid = s / ss;
        did = (s % ss) / CHUNK;
        // open a stripe: clear the map, rotate parity, set the base
        if (!open || cur != sid) begin
          foreach (usage[i]) usage[i] = rrs_pkg::USE_NONE;
          open = 1;
          cur = sid;
          par = sid % n;
          base = (sid * ss + s % CHUNK) & MASK48;
          usage[par] = rrs_pkg::USE_FULL;
          if (wr) list.push_back('{par[2:0], base[47:0], l[20:0], wr,
                                   rrs_pkg::KIND_PARITY, 1'b0});
        end
        disk = (did < par) ? did : did + 1;
        usage[disk] = (l >= CHUNK) ? rrs_pkg::USE_FULL : rrs_pkg::USE_PART;
        list.push_back('{disk[2:0], base[47:0], l[20:0], wr, rrs_pkg::KIND_DATA, 1'b0});
      end
      if (wr) begin
        cnt = 0;
        for (int i = 0; i < n; i++) if (usage[i] != rrs_pkg::USE_FULL) cnt++;
        rcw = (cnt <= n / 2);
        for (int i = 0; i < n; i++)
          if (rcw ? (usage[i] != rrs_pkg::USE_FULL) : (usage[i] != rrs_pkg::USE_NONE))
            list.push_back('{i[2:0], base[47:0], rrs_pkg::LEN_W'(CHUNK), 1'b0,
                             rrs_pkg::KIND_PRE, 1'b0});
      end
    end
    if (len > rrs_pkg::MAX_REQ_LEN || list.size() > 64) begin
      list.delete();
      list.push_back('{3'd0, off, len, wr, rrs_pkg::KIND_ERR, 1'b0});
    end
    list[list.size()-1].last = 1'b1;
    foreach (list[i]) pending_pieces.push_back(list[i]);
  endfunction

  // Offer one request, after a random gap unless no_stall is set, and hold it until taken.
  task automatic send_request(input logic [rrs_pkg::ADDR_W-1:0] off,
                              input logic [rrs_pkg::LEN_W-1:0] len, input logic wr);
    if (!no_stall) repeat ($urandom_range(16)) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {3'b0, len, off};
    in_tuser  = wr;
    do @(posedge clk); while (!in_tready);
    split_request(off, len, wr);
    requests_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Drain every expected piece, then let the block settle before touching it.
  task automatic wait_idle();
    while (pending_pieces.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_disks(input logic [3:0] v);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    disk_setting = v;
  endtask

  // Random offset: aligned, near the top of the address space, or anywhere.
  function automatic logic [rrs_pkg::ADDR_W-1:0] pick_offset();
    logic [rrs_pkg::ADDR_W-1:0] o;
    o = {$urandom, $urandom};
    case ($urandom_range(3))
      0: o = {o[47:32] & 16'h000f, 32'h0} | (o & 48'h0);
      1: o = MASK48[47:0] - 48'($urandom_range(300000));
      2: o = o & ~48'(CHUNK - 1);
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic [rrs_pkg::LEN_W-1:0] pick_length();
    case ($urandom_range(9))
      0: return rrs_pkg::LEN_W'($urandom_range(2097151, rrs_pkg::MAX_REQ_LEN + 1));
      1: return '0;
      2: return rrs_pkg::LEN_W'($urandom_range(rrs_pkg::MAX_REQ_LEN, 1));
      3: return rrs_pkg::LEN_W'(CHUNK * $urandom_range(16, 1));
      default: return rrs_pkg::LEN_W'($urandom_range(3 * CHUNK, 1));
    endcase
  endfunction

  task automatic test_edges();
    send_request(48'd0, 21'd0, 1'b1);
    send_request(48'd0, 21'd1, 1'b0);
    send_request(48'd0, rrs_pkg::LEN_W'(CHUNK), 1'b1);
    send_request(48'd0, rrs_pkg::LEN_W'(rrs_pkg::MAX_REQ_LEN), 1'b1);
    send_request(48'd100, rrs_pkg::LEN_W'(rrs_pkg::MAX_REQ_LEN), 1'b1);
    send_request(48'd100, rrs_pkg::LEN_W'(rrs_pkg::MAX_REQ_LEN), 1'b0);
    send_request(48'd5, rrs_pkg::LEN_W'(rrs_pkg::MAX_REQ_LEN + 1), 1'b1);
    send_request(MASK48[47:0], 21'h1FFFFF, 1'b0);
    send_request(MASK48[47:0] - 48'd1000, rrs_pkg::LEN_W'(rrs_pkg::MAX_REQ_LEN), 1'b1);
    send_request(48'(CHUNK * 3 - 10), 21'd20, 1'b1);
    send_request(48'(CHUNK * 7), rrs_pkg::LEN_W'(CHUNK * 2), 1'b1);
  endtask

  task automatic test_disk_counts();
    logic [3:0] counts[6] = '{4'd0, 4'd3, 4'd8, 4'd15, 4'd5, 4'd2};
    foreach (counts[i]) begin
      set_disks(counts[i]);
      send_request(48'd0, rrs_pkg::LEN_W'(CHUNK * 5), 1'b1);
      send_request(48'(CHUNK + 7), rrs_pkg::LEN_W'(CHUNK * 4), 1'b1);
    end
  endtask

  task automatic test_random();
    logic [3:0] counts[5] = '{4'd4, 4'd3, 4'd8, 4'd6, 4'd4};
    foreach (counts[i]) begin
      set_disks(counts[i]);
      no_stall = (i == 2);
      repeat (16) send_request(pick_offset(), pick_length(), 1'($urandom_range(1)));
      // hold off new work until the block has drained
      while (pending_pieces.size() != 0) @(negedge clk);
      repeat (4) send_request(pick_offset(), pick_length(), 1'($urandom_range(1)));
    end
    no_stall = 0;
  endtask

  // Result side: random back-pressure per piece unless no_stall is set.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_tready = 1'b0;
      if (!no_stall) repeat ($urandom_range(16)) @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare each taken piece with the oldest expectation.
  always @(posedge clk) begin
    piece_t want;
    if (rst_n && out_tvalid && out_tready) begin
      pieces_seen++;
      if (pending_pieces.size() == 0) begin
        report($sformatf("unexpected piece tdata=%h tuser=%h", out_tdata, out_tuser));
      end else begin
        want = pending_pieces.pop_front();
        if (out_tdata[2:0] !== want.disk)
          report($sformatf("disk %0d, want %0d", out_tdata[2:0], want.disk));
        if (out_tdata[50:3] !== want.offset)
          report($sformatf("offset %h, want %h", out_tdata[50:3], want.offset));
        if (out_tdata[71:51] !== want.length)
          report($sformatf("length %0d, want %0d", out_tdata[71:51], want.length));
        if (out_tuser[0] !== want.is_write)
          report($sformatf("is_write %b, want %b", out_tuser[0], want.is_write));
        if (out_tuser[2:1] !== want.kind)
          report($sformatf("kind %0d, want %0d", out_tuser[2:1], want.kind));
        if (out_tlast !== want.last)
          report($sformatf("last %b, want %b", out_tlast, want.last));
      end
    end
  end

  // Watchdog: count cycles spent waiting on the block with nothing moving.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (!in_tvalid && pending_pieces.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    disk_setting = 4'd4;
    mismatches = 0;
    requests_sent = 0;
    pieces_seen = 0;
    idle_cycles = 0;
    no_stall = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_edges();
    test_disk_counts();
    test_random();
    wait_idle();
    if (pending_pieces.size() != 0) report("pieces still expected at end");
    $display("covered %0d requests and %0d pieces over in-range and clamped disk counts,",
             requests_sent, pieces_seen);
    $display("reads, writes, zero and oversize lengths, address wrap, random stalls");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
